// ----- design/ptw_pkg.sv -----
// Shared types, codes and index helpers for the page table walker.
package ptw_pkg;

  localparam int AddrWidth  = 48;
  localparam int EntryWidth = 64;
  localparam int PageShift  = 12;
  localparam int IdxBits    = 9;
  localparam int PageWidth  = AddrWidth - PageShift;

  localparam logic       MODE_REQUEST = 1'b0;
  localparam logic       MODE_ENTRY   = 1'b1;
  localparam logic       KIND_READ    = 1'b0;
  localparam logic       KIND_DONE    = 1'b1;
  localparam logic [1:0] LOW_TABLE    = 2'b11;
  localparam logic [1:0] LOW_BLOCK    = 2'b01;
  localparam logic [1:0] LEVEL_LAST   = 2'd3;

  typedef struct packed {
    logic                  mode;
    logic [AddrWidth-1:0]  virtual_address;
    logic [EntryWidth-1:0] entry_data;
  } item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [AddrWidth-1:0] read_address;
    logic [AddrWidth-1:0] physical_address;
    logic                 fault;
    logic [1:0]           final_level;
  } result_t;

  function automatic logic [IdxBits-1:0] va_index(input logic [AddrWidth-1:0] va,
                                                  input logic [1:0] lvl);
    logic [IdxBits-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [AddrWidth-1:0] level_offset(input logic [AddrWidth-1:0] va,
                                                        input logic [1:0] lvl);
    logic [AddrWidth-1:0] off;
    case (lvl)
      2'd0:    off = {9'd0, va[38:0]};
      2'd1:    off = {18'd0, va[29:0]};
      2'd2:    off = {27'd0, va[20:0]};
      default: off = {36'd0, va[11:0]};
    endcase
    return off;
  endfunction

endpackage

// ----- design/ptw_walk.sv -----
// Walk state registers and combinational descriptor decode.
module ptw_walk import ptw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [AddrWidth-1:0] root_base,
  input  item_t                item,
  input  logic                 advance,
  output logic                 has_result,
  output result_t              res
);

  logic                 busy;
  logic [1:0]           level;
  logic [AddrWidth-1:0] saved_va;
  logic [PageWidth-1:0] base_page;

  logic                 busy_next;
  logic [1:0]           level_next;
  logic [AddrWidth-1:0] saved_va_next;
  logic [PageWidth-1:0] base_page_next;
  logic [1:0]           low;

  assign low = item.entry_data[1:0];

  always_comb begin
    busy_next      = busy;
    level_next     = level;
    saved_va_next  = saved_va;
    base_page_next = base_page;
    has_result     = 1'b0;
    res            = '0;
    if (item.mode == MODE_REQUEST) begin
      if (!busy) begin
        busy_next       = 1'b1;
        level_next      = 2'd0;
        saved_va_next   = item.virtual_address;
        base_page_next  = root_base[AddrWidth-1:PageShift];
        has_result      = 1'b1;
        res.result_kind = KIND_READ;
        res.final_level = 2'd0;
        res.read_address = {root_base[AddrWidth-1:PageShift],
                            va_index(item.virtual_address, 2'd0), 3'b000};
      end
    end else if (busy) begin
      has_result      = 1'b1;
      res.final_level = level;
      if (level != LEVEL_LAST && low == LOW_TABLE) begin
        level_next       = level + 2'd1;
        base_page_next   = item.entry_data[AddrWidth-1:PageShift];
        res.result_kind  = KIND_READ;
        res.final_level  = level + 2'd1;
        res.read_address = {item.entry_data[AddrWidth-1:PageShift],
                            va_index(saved_va, level + 2'd1), 3'b000};
      end else if ((level != LEVEL_LAST && low == LOW_BLOCK) ||
                   (level == LEVEL_LAST && low == LOW_TABLE)) begin
        busy_next            = 1'b0;
        res.result_kind      = KIND_DONE;
        res.physical_address = {item.entry_data[AddrWidth-1:PageShift], 12'd0} |
                               level_offset(saved_va, level);
      end else begin
        busy_next       = 1'b0;
        res.result_kind = KIND_DONE;
        res.fault       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      level     <= 2'd0;
      saved_va  <= '0;
      base_page <= '0;
    end else if (advance) begin
      busy      <= busy_next;
      level     <= level_next;
      saved_va  <= saved_va_next;
      base_page <= base_page_next;
    end
  end

endmodule

// ----- design/ptw_out_reg.sv -----
// Result register holding one beat for the downstream side.
module ptw_out_reg import ptw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    can_take,
  output logic    out_valid,
  output result_t out_res
);

  assign can_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      out_res <= res;
    end
  end

endmodule

// ----- design/page_table_walker_unit.sv -----
// Top level of the four-level page table walker.
//
//  channel  handshake               payload
//  in       in_valid / in_stall     mode, virtual_address, entry_data
//  out      out_valid / out_stall   result_kind, read_address, physical_address,
//                                   fault, final_level
//  cfg      cfg_write_enable        cfg_write_data (root table base)
//
// One beat enters per cycle while in_stall is low; any result it yields leaves
// through the input register and the result register around the decode.
// A stalled result holds the result register; the input register then fills
// and in_stall rises until the result is taken.
// Reset clears the walk state, both valid flags and the root base.
module page_table_walker_unit import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [AddrWidth-1:0]  cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [AddrWidth-1:0]  virtual_address,
  input  logic [EntryWidth-1:0] entry_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic [AddrWidth-1:0]  read_address,
  output logic [AddrWidth-1:0]  physical_address,
  output logic                  fault,
  output logic [1:0]            final_level
);

  logic [AddrWidth-1:0] root_base;
  logic                 in_reg_valid;
  item_t                in_reg;
  logic                 can_take;
  logic                 advance;
  logic                 accept;
  logic                 has_result;
  result_t              res;
  result_t              out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base <= '0;
    end else if (cfg_write_enable) begin
      root_base <= cfg_write_data;
    end
  end

  assign advance  = in_reg_valid && can_take;
  assign in_stall = in_reg_valid && !can_take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg.mode            <= mode;
      in_reg.virtual_address <= virtual_address;
      in_reg.entry_data      <= entry_data;
    end
  end

  ptw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .root_base  (root_base),
    .item       (in_reg),
    .advance    (advance),
    .has_result (has_result),
    .res        (res)
  );

  ptw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .res       (res),
    .out_stall (out_stall),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign result_kind      = out_res.result_kind;
  assign read_address     = out_res.read_address;
  assign physical_address = out_res.physical_address;
  assign fault            = out_res.fault;
  assign final_level      = out_res.final_level;

  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_DONE |-> read_address == '0)
    else $error("finished result carries a read address");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_READ || fault) |-> physical_address == '0)
    else $error("read request or fault carries a physical address");

  a_dropped_beat: assert property (@(posedge clk) disable iff (rst)
    advance && !has_result |=> !out_valid)
    else $error("ignored beat produced a result");

endmodule

// ----- verif/page_table_walker_unit_tb.sv -----
// Testbench for page_table_walker_unit: directed walks from a table, then random walks.
module page_table_walker_unit_tb import ptw_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRows      = 26;
  localparam int PhaseItems   = 263;
  localparam int SettleCycles = 6;
  localparam int CycleLimit   = 400000;

  typedef struct packed {
    logic                  mode;
    logic [AddrWidth-1:0]  va;
    logic [EntryWidth-1:0] entry;
    logic                  typed;
    result_t               want;
  } walk_row_t;

  localparam result_t NoResult = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_enable = 1'b0;
  logic [AddrWidth-1:0]  cfg_write_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = MODE_REQUEST;
  logic [AddrWidth-1:0]  virtual_address = '0;
  logic [EntryWidth-1:0] entry_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  result_kind;
  logic [AddrWidth-1:0]  read_address;
  logic [AddrWidth-1:0]  physical_address;
  logic                  fault;
  logic [1:0]            final_level;

  logic                 wk_busy = 1'b0;
  logic [1:0]           wk_level = '0;
  logic [AddrWidth-1:0] wk_va = '0;
  logic [PageWidth-1:0] wk_page = '0;
  logic [AddrWidth-1:0] wk_root = '0;

  result_t   pending_walk_results[$];
  result_t   head;
  walk_row_t walk_rows [NumRows];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  page_table_walker_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .virtual_address  (virtual_address),
    .entry_data       (entry_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .read_address     (read_address),
    .physical_address (physical_address),
    .fault            (fault),
    .final_level      (final_level)
  );

  always #10 clk = ~clk;

  function automatic logic [AddrWidth-1:0] rand_va();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [EntryWidth-1:0] rand_entry();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic int level_shift(input logic [1:0] lvl);
    return (3 - int'(lvl)) * IdxBits + PageShift;
  endfunction

  function automatic logic [AddrWidth-1:0] entry_addr();
    logic [IdxBits-1:0] idx;
    idx = IdxBits'(wk_va >> level_shift(wk_level));
    return {wk_page, 12'h000} | {36'd0, idx, 3'd0};
  endfunction

  task automatic walk_advance(input item_t it, output bit produced, output result_t res);
    logic [1:0]           lvl;
    logic [1:0]           low;
    logic [AddrWidth-1:0] off;
    produced = 1'b0;
    res = NoResult;
    lvl = wk_level;
    low = it.entry_data[1:0];
    if (it.mode == MODE_REQUEST) begin
      if (!wk_busy) begin
        wk_busy = 1'b1;
        wk_level = 2'd0;
        wk_va = it.virtual_address;
        wk_page = wk_root[AddrWidth-1:PageShift];
        res.result_kind = KIND_READ;
        res.read_address = entry_addr();
        res.final_level = wk_level;
        produced = 1'b1;
      end
    end else if (wk_busy) begin
      produced = 1'b1;
      res.result_kind = KIND_DONE;
      res.final_level = lvl;
      if (lvl != LEVEL_LAST && low == LOW_TABLE) begin
        wk_page = it.entry_data[AddrWidth-1:PageShift];
        wk_level = lvl + 2'd1;
        res.result_kind = KIND_READ;
        res.read_address = entry_addr();
        res.final_level = wk_level;
      end else if ((lvl != LEVEL_LAST && low == LOW_BLOCK) ||
                   (lvl == LEVEL_LAST && low == LOW_TABLE)) begin
        off = ((48'd1 << level_shift(lvl)) - 48'd1) & wk_va;
        res.physical_address = {it.entry_data[AddrWidth-1:PageShift], 12'h000} | off;
        wk_busy = 1'b0;
      end else begin
        res.fault = 1'b1;
        wk_busy = 1'b0;
      end
    end
  endtask

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h, actual %h", what, want, got);
  endfunction

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got)
      flag_mismatch(what, want, got);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_walk_results.size() == 0) begin
        flag_mismatch("result with none due", 64'd0, 64'(read_address));
      end else begin
        head = pending_walk_results.pop_front();
        compare_field("result_kind", 64'(head.result_kind), 64'(result_kind));
        compare_field("read_address", 64'(head.read_address), 64'(read_address));
        compare_field("physical_address", 64'(head.physical_address), 64'(physical_address));
        compare_field("fault", 64'(head.fault), 64'(fault));
        compare_field("final_level", 64'(head.final_level), 64'(final_level));
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("page_table_walker_unit_tb failed");
    $finish;
  end

  task automatic send_beat(input item_t it, output bit produced, output result_t res);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    mode <= it.mode;
    virtual_address <= it.virtual_address;
    entry_data <= it.entry_data;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    walk_advance(it, produced, res);
  endtask

  task automatic settle_walks();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_walk_results.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_root(input logic [AddrWidth-1:0] value);
    cfg_write_data <= value;
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    wk_root = value;
  endtask

  function automatic item_t next_walk_item();
    item_t      it;
    int         pick;
    logic [1:0] low;
    it.mode = MODE_ENTRY;
    it.virtual_address = rand_va();
    it.entry_data = rand_entry();
    pick = $urandom_range(99);
    if (!wk_busy) begin
      if (pick < 92) it.mode = MODE_REQUEST;
      if (pick < 3) it.virtual_address = '0;
      else if (pick < 6) it.virtual_address = '1;
    end else if (pick < 6) begin
      it.mode = MODE_REQUEST;
    end else begin
      pick = $urandom_range(99);
      if (wk_level != LEVEL_LAST) begin
        if (pick < 55) low = LOW_TABLE;
        else if (pick < 80) low = LOW_BLOCK;
        else low = {1'($urandom), 1'b0};
      end else begin
        if (pick < 75) low = LOW_TABLE;
        else low = 2'($urandom_range(2));
      end
      it.entry_data[1:0] = low;
    end
    return it;
  endfunction

  initial begin
    item_t                idx_item;
    bit                   produced;
    result_t              res;
    int                   counted;
    int                   phase_idle [4];
    int                   phase_stall [4];
    logic [AddrWidth-1:0] phase_root [4];

    walk_rows = '{
      '{MODE_REQUEST, 48'h0, 64'h0, 1'b1, '{KIND_READ, 48'h0, 48'h0, 1'b0, 2'd0}},
      '{MODE_ENTRY, 48'h0, 64'h0, 1'b1, '{KIND_DONE, 48'h0, 48'h0, 1'b1, 2'd0}},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NoResult},
      '{MODE_REQUEST, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b1,
        '{KIND_READ, 48'h0000_0000_0FF8, 48'h0, 1'b0, 2'd0}},
      '{MODE_REQUEST, 48'h0, 64'h0, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{KIND_READ, 48'hFFFF_FFFF_FFF8, 48'h0, 1'b0, 2'd1}},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{KIND_READ, 48'hFFFF_FFFF_FFF8, 48'h0, 1'b0, 2'd2}},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{KIND_READ, 48'hFFFF_FFFF_FFF8, 48'h0, 1'b0, 2'd3}},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        '{KIND_DONE, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 2'd3}},
      '{MODE_REQUEST, 48'h1234_5678_9ABC, 64'h0, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'hDEAD_0000_8765_4001, 1'b0, NoResult},
      '{MODE_REQUEST, 48'hA5A5_5A5A_C3C3, 64'h0, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h0000_1357_9BDF_E003, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_2468_ACE0_1FFD, 1'b0, NoResult},
      '{MODE_REQUEST, 48'h0F0F_F0F0_0FF0, 64'h0, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h0000_0000_0000_1003, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h8000_7FFF_FFFF_F003, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h0000_0000_2000_0001, 1'b0, NoResult},
      '{MODE_REQUEST, 48'h8000_0000_0001, 64'h0, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h0000_0000_0000_0003, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h0000_0000_0000_0003, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h5555_5555_5555_5555, 1'b1,
        '{KIND_DONE, 48'h0, 48'h0, 1'b1, 2'd3}},
      '{MODE_REQUEST, 48'h0000_8000_0000, 64'h0, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'h0000_0000_0000_FFF3, 1'b0, NoResult},
      '{MODE_ENTRY, 48'h0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
        '{KIND_DONE, 48'h0, 48'h0, 1'b1, 2'd1}}
    };
    phase_idle  = '{0, 52, 0, 21};
    phase_stall = '{0, 0, 52, 21};
    phase_root  = '{48'hFFFF_FFFF_FFFF, 48'h0, rand_va(), rand_va()};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumRows; r++) begin
      idx_item.mode = walk_rows[r].mode;
      idx_item.virtual_address = walk_rows[r].va;
      idx_item.entry_data = walk_rows[r].entry;
      send_beat(idx_item, produced, res);
      if (produced)
        pending_walk_results.push_back(walk_rows[r].typed ? walk_rows[r].want : res);
    end

    for (int p = 0; p < 4; p++) begin
      settle_walks();
      write_root(phase_root[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      counted = 0;
      while (counted < PhaseItems) begin
        if ($urandom_range(149) == 0)
          settle_walks();
        send_beat(next_walk_item(), produced, res);
        if (produced) begin
          pending_walk_results.push_back(res);
          counted++;
        end
      end
    end

    settle_walks();
    if (fail_count == 0 && pending_walk_results.size() == 0) begin
      $display("page_table_walker_unit_tb passed");
    end else begin
      $display("page_table_walker_unit_tb failed");
    end
    $finish;
  end

endmodule

// ----- page_table_walker_unit.f -----
design/ptw_pkg.sv
design/ptw_walk.sv
design/ptw_out_reg.sv
design/page_table_walker_unit.sv
verif/page_table_walker_unit_tb.sv
